// ===== sv/cfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cube face to equirectangular sampler.
// Depends on nothing; used by cfe_cordic and the top level.
package cfe_pkg;

	localparam int ANG_W = 34;
	localparam int VEC_W = 22;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FACE_SIZE  = 2'd2;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd2147483648;

	function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
		logic signed [ANG_W-1:0] t;
		begin
			case (i)
				0: t = 34'sd536870912;
				1: t = 34'sd316933406;
				2: t = 34'sd167458908;
				3: t = 34'sd85004756;
				4: t = 34'sd42667331;
				5: t = 34'sd21354465;
				6: t = 34'sd10679838;
				7: t = 34'sd5340245;
				8: t = 34'sd2670163;
				9: t = 34'sd1335087;
				10: t = 34'sd667544;
				11: t = 34'sd333772;
				12: t = 34'sd166886;
				13: t = 34'sd83443;
				14: t = 34'sd41722;
				15: t = 34'sd20861;
				16: t = 34'sd10430;
				17: t = 34'sd5215;
				18: t = 34'sd2608;
				19: t = 34'sd1304;
				20: t = 34'sd652;
				21: t = 34'sd326;
				22: t = 34'sd163;
				23: t = 34'sd81;
				24: t = 34'sd41;
				25: t = 34'sd20;
				26: t = 34'sd10;
				27: t = 34'sd5;
				28: t = 34'sd3;
				29: t = 34'sd1;
				30: t = 34'sd1;
				default: t = 34'sd0;
			endcase
			return t;
		end
	endfunction

endpackage

// ===== sv/cfe_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; stalls through the shared advance enable.
module cfe_div #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	logic [NUM_W-1:0] q_s [NUM_W+1];
	logic [DEN_W:0]   r_s [NUM_W+1];
	logic [DEN_W-1:0] d_s [NUM_W+1];

	assign q_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_bit
		logic [DEN_W+1:0] trial;
		logic [DEN_W:0]   rn;
		logic [NUM_W-1:0] qn;
		always_comb begin
			trial = {r_s[k], q_s[k][NUM_W-1]};
			if (trial >= {2'b00, d_s[k]}) begin
				rn = (DEN_W+1)'(trial - {2'b00, d_s[k]});
				qn = {q_s[k][NUM_W-2:0], 1'b1};
			end else begin
				rn = trial[DEN_W:0];
				qn = {q_s[k][NUM_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= rn;
				q_s[k+1] <= qn;
				d_s[k+1] <= d_s[k];
			end
		end
	end

	assign quo = q_s[NUM_W];
endmodule

// ===== sv/cfe_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC giving atan2 in binary turns, one iteration per stage.
// Depends on cfe_pkg for the arctangent table and angle width.
module cfe_cordic #(
	parameter int ITERS = 18,
	parameter int XW = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [XW-1:0]          px,
	input  logic signed [XW-1:0]          py,
	output logic signed [cfe_pkg::ANG_W-1:0] ang
);
	import cfe_pkg::*;
	localparam int N = (ITERS < 32) ? ITERS : 32;
	localparam int W = XW + 2;

	logic signed [W-1:0]     x_s [N+1];
	logic signed [W-1:0]     y_s [N+1];
	logic signed [ANG_W-1:0] a_s [N+1];
	logic                    z_s [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= (px == '0) && (py == '0);
			if (px < 0) begin
				x_s[0] <= -W'(px);
				y_s[0] <= -W'(py);
				a_s[0] <= HALF_TURN;
			end else begin
				x_s[0] <= W'(px);
				y_s[0] <= W'(py);
				a_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_turn(i);
				end
			end
		end
	end

	assign ang = z_s[N] ? '0 : a_s[N];
endmodule

// ===== sv/cube_face_to_equirect_sampler.sv =====
`timescale 1ns / 1ps
// Cube face pixel to equirectangular bilinear sample coordinates.
// Depends on cfe_pkg, cfe_div and cfe_cordic.
// Takes one word per cycle and returns one per cycle unless a held output word stalls the
// pipeline; with the default parameters it has a numerator stage, the divider (30 stages),
// direction and square stages, an isqrt of 20 stages, a CORDIC of CORDIC_ITERS+1 stages
// and three scaling stages, all under one shared stall enable.
module cube_face_to_equirect_sampler #(
	parameter int MAX_SRC_WIDTH = 8192,
	parameter int MAX_FACE_SIZE = 4096,
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  face,
	input  logic [11:0] pix_x,
	input  logic [11:0] pix_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [12:0] src_x0,
	output logic [12:0] src_x1,
	output logic [11:0] src_y0,
	output logic [11:0] src_y1,
	output logic [15:0] frac_x,
	output logic [15:0] frac_y
);
	import cfe_pkg::*;

	localparam int NUM_W = 13 + FRAC_BITS + 1;
	localparam int FS_W  = $clog2(MAX_FACE_SIZE + 1);
	localparam int SW_W  = $clog2(MAX_SRC_WIDTH + 1);
	localparam int CW    = FRAC_BITS + 3;
	localparam int SQ_W  = 2 * CW + 2;
	localparam int SQ_N  = SQ_W / 2;
	localparam int CN    = (CORDIC_ITERS < 32) ? CORDIC_ITERS : 32;
	localparam int LAT   = NUM_W + 3 + SQ_N + 1 + CN + 3;
	localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

	logic [13:0] src_width_q;
	logic [12:0] src_height_q, face_size_q;
	logic [SW_W-1:0] w_c;
	logic [12:0] h_c;
	logic [FS_W-1:0] fs_c;
	logic en;
	logic [LAT-1:0] vld_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 14'd2048;
			src_height_q <= 13'd1024;
			face_size_q  <= 13'd1024;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data[12:0];
				REG_FACE_SIZE:  face_size_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_width_q == '0) w_c = SW_W'(1);
		else if (32'(src_width_q) > MAX_SRC_WIDTH) w_c = SW_W'(MAX_SRC_WIDTH);
		else w_c = SW_W'(src_width_q);
		if (src_height_q == '0) h_c = 13'd1;
		else if (src_height_q > 13'd4096) h_c = 13'd4096;
		else h_c = src_height_q;
		if (face_size_q == '0) fs_c = FS_W'(1);
		else if (32'(face_size_q) > MAX_FACE_SIZE) fs_c = FS_W'(MAX_FACE_SIZE);
		else fs_c = FS_W'(face_size_q);
	end

	// advance all stages unless the output word is held
	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// stage 1: numerators
	logic [NUM_W-1:0] nx_s1, ny_s1;
	logic [FS_W-1:0] fs_s1;
	logic [2:0] face_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= NUM_W'({pix_x, 1'b1}) << FRAC_BITS;
			ny_s1 <= NUM_W'({pix_y, 1'b1}) << FRAC_BITS;
			fs_s1 <= fs_c;
			face_s1 <= face;
		end
	end

	logic [NUM_W-1:0] qx, qy;
	cfe_div #(.NUM_W(NUM_W), .DEN_W(FS_W)) u_divx (
		.clk(clk), .en(en), .num(nx_s1), .den(fs_s1), .quo(qx));
	cfe_div #(.NUM_W(NUM_W), .DEN_W(FS_W)) u_divy (
		.clk(clk), .en(en), .num(ny_s1), .den(fs_s1), .quo(qy));

	logic [2:0] face_d [NUM_W];
	always_ff @(posedge clk) begin
		if (en) begin
			face_d[0] <= face_s1;
			for (int k = 1; k < NUM_W; k++) face_d[k] <= face_d[k-1];
		end
	end

	// direction stage
	logic signed [CW-1:0] u_c, v_c, dx_c, dy_c, dz_c;
	logic signed [NUM_W+1:0] ux_w, vy_w;
	always_comb begin
		ux_w = $signed({2'b00, qx}) - (NUM_W+2)'(ONE);
		vy_w = $signed({2'b00, qy}) - (NUM_W+2)'(ONE);
		u_c = (ux_w > (NUM_W+2)'(ONE)) ? ONE : CW'(ux_w);
		v_c = (vy_w > (NUM_W+2)'(ONE)) ? ONE : CW'(vy_w);
		case (face_d[NUM_W-1])
			FACE_PX: begin dx_c = ONE;  dy_c = -v_c; dz_c = -u_c; end
			FACE_NX: begin dx_c = -ONE; dy_c = -v_c; dz_c = u_c;  end
			FACE_PY: begin dx_c = u_c;  dy_c = ONE;  dz_c = v_c;  end
			FACE_NY: begin dx_c = u_c;  dy_c = -ONE; dz_c = -v_c; end
			FACE_PZ: begin dx_c = u_c;  dy_c = -v_c; dz_c = ONE;  end
			FACE_NZ: begin dx_c = -u_c; dy_c = -v_c; dz_c = -ONE; end
			default: begin dx_c = '0;   dy_c = '0;   dz_c = ONE;  end
		endcase
	end

	logic signed [CW-1:0] dx_s2, dy_s2, dz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2 <= dx_c;
			dy_s2 <= dy_c;
			dz_s2 <= dz_c;
		end
	end

	// squares
	logic signed [2*CW-1:0] dxx_c, dzz_c;
	assign dxx_c = dx_s2 * dx_s2;
	assign dzz_c = dz_s2 * dz_s2;

	logic [SQ_W-1:0] sq_s3;
	logic signed [CW-1:0] dx_s3, dy_s3, dz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= SQ_W'($unsigned(dxx_c)) + SQ_W'($unsigned(dzz_c));
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			dz_s3 <= dz_s2;
		end
	end

	// pipelined isqrt, one result bit per stage
	logic [SQ_W-1:0] sn_s [SQ_N+1];
	logic [SQ_W-1:0] sr_s [SQ_N+1];
	logic signed [CW-1:0] sx_s [SQ_N+1];
	logic signed [CW-1:0] sy_s [SQ_N+1];
	logic signed [CW-1:0] sz_s [SQ_N+1];
	assign sn_s[0] = sq_s3;
	assign sr_s[0] = '0;
	assign sx_s[0] = dx_s3;
	assign sy_s[0] = dy_s3;
	assign sz_s[0] = dz_s3;
	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - k));
		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[k+1] <= sx_s[k];
				sy_s[k+1] <= sy_s[k];
				sz_s[k+1] <= sz_s[k];
				if (sn_s[k] >= sr_s[k] + BIT) begin
					sn_s[k+1] <= sn_s[k] - (sr_s[k] + BIT);
					sr_s[k+1] <= (sr_s[k] >> 1) + BIT;
				end else begin
					sn_s[k+1] <= sn_s[k];
					sr_s[k+1] <= sr_s[k] >> 1;
				end
			end
		end
	end

	logic signed [ANG_W-1:0] lon, lat;
	cfe_cordic #(.ITERS(CORDIC_ITERS), .XW(CW + 1)) u_lon (
		.clk(clk), .en(en), .px((CW+1)'(sx_s[SQ_N])), .py((CW+1)'(sz_s[SQ_N])),
		.ang(lon));
	cfe_cordic #(.ITERS(CORDIC_ITERS), .XW(CW + 1)) u_lat (
		.clk(clk), .en(en), .px((CW+1)'(sy_s[SQ_N])),
		.py($signed({1'b0, sr_s[SQ_N][CW-1:0]})), .ang(lat));

	// angle to texel fraction
	logic [31:0] uf_s4, vf_lo;
	logic vf_one;
	logic [32:0] vf_s4;
	always_comb begin
		if (lat < 0) vf_lo = '0;
		else vf_lo = {lat[30:0], 1'b0};
		vf_one = (lat >= HALF_TURN);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			uf_s4 <= 32'(lon + HALF_TURN);
			vf_s4 <= vf_one ? 33'h1_0000_0000 : {1'b0, vf_lo};
		end
	end

	logic [32+SW_W-1:0] px_s5;
	logic [45:0] py_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= (32+SW_W)'(uf_s4) * (32+SW_W)'(w_c - SW_W'(1));
			py_s5 <= 46'(vf_s4) * 46'(h_c - 13'd1);
		end
	end

	logic [SW_W:0] x0_c;
	logic [12:0] y0_c;
	assign x0_c = (SW_W+1)'(px_s5 >> 32);
	assign y0_c = 13'(py_s5 >> 32);
	always_ff @(posedge clk) begin
		if (en) begin
			src_x0 <= 13'(x0_c);
			src_x1 <= (x0_c + 1'b1 >= (SW_W+1)'(w_c)) ? 13'd0 : 13'(x0_c + 1'b1);
			src_y0 <= y0_c[11:0];
			src_y1 <= (y0_c + 13'd1 > h_c - 13'd1) ? 12'(h_c - 13'd1) : 12'(y0_c + 13'd1);
			frac_x <= px_s5[31:16];
			frac_y <= py_s5[31:16];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_x0) && $stable(frac_y))
		else $error("held word changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> src_y1 >= src_y0 || src_y1 == 12'(h_c - 13'd1))
		else $error("row neighbour out of order");
endmodule
